>>> rtl/hslrgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Widths, constants and helpers shared by the HSL to RGB pipeline.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

	localparam int CH_W  = 9;   // hue, saturation, lightness
	localparam int LVL_W = 19;  // signed level, units of 2^-16
	localparam int POS_W = 11;  // signed hue position before wrap
	localparam int DEG_W = 9;   // wrapped hue position, 0..360
	localparam int K_W   = 6;   // ramp weight, 0..60
	localparam int NUM_W = 26;  // signed ramp numerator
	localparam int Q_W   = 12;  // scaled value before divide by 15
	localparam int RGB_W = 8;

	localparam logic signed [POS_W-1:0] FULL_DEG_S  = 11'sd360;
	localparam logic signed [POS_W-1:0] THIRD_DEG_S = 11'sd120;
	localparam logic [DEG_W-1:0] SIXTH_DEG = 9'd60;
	localparam logic [DEG_W-1:0] HALF_DEG  = 9'd180;
	localparam logic [DEG_W-1:0] FALL_END  = 9'd240;
	localparam logic [K_W-1:0]   K_FULL    = 6'd60;
	localparam logic [CH_W-1:0]  HALF_L    = 9'd128;

	// 255*15: any scaled value at or above this gives full scale
	localparam logic [Q_W-1:0] Q_CAP       = 12'd3825;
	// ceil(2^18 / 15); exact floor(q/15) for q up to Q_CAP
	localparam logic [14:0]    RECIP_15    = 15'd17477;
	localparam int             RECIP_SHIFT = 18;

	typedef struct packed {
		logic s3;
		logic s4;
	} scale_en_t;

	// wrap once into 0..360 (360 itself stays)
	function automatic logic [DEG_W-1:0] wrap_pos(input logic signed [POS_W-1:0] p);
		logic signed [POS_W-1:0] t;
		t = p;
		if (t < 0)
			t = t + FULL_DEG_S;
		if (t > FULL_DEG_S)
			t = t - FULL_DEG_S;
		return t[DEG_W-1:0];
	endfunction

	// weight of the high level on the hue ramp, in sixtieths
	function automatic logic [K_W-1:0] ramp_weight(input logic [DEG_W-1:0] pos);
		logic [DEG_W-1:0] d;
		logic [K_W-1:0]   k;
		d = FALL_END - pos;
		if (pos < SIXTH_DEG)
			k = pos[K_W-1:0];
		else if (pos < HALF_DEG)
			k = K_FULL;
		else if (pos < FALL_END)
			k = d[K_W-1:0];
		else
			k = '0;
		return k;
	endfunction

endpackage
`default_nettype wire

>>> rtl/hsl_to_rgb_convert_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_to_rgb_convert_unit
// HSL to 8-bit RGB color conversion, four-stage pipeline.
// ----------------------------------------------------------------------------
// Input stream: one word per color, s_axis_tdata = {pad, lightness,
// saturation, hue_deg}. Hue is in degrees, saturation and lightness in
// units of 1/256. Output stream: one word per color, m_axis_tdata =
// {pad, blue, green, red}.
//
// Four register stages: levels and hue weights, level blend (two
// multiplies per channel), scale by 255, and the divide by 15 through a
// reciprocal multiply. The result leaves from the last stage register. A
// new word is accepted every cycle unless the pipeline is full and stalled.
//
// Each stage moves when it is empty or the stage after it moves, so a
// stall on m_axis_tready holds every word in place and bubbles close up;
// s_axis_tready drops only when all four stages are full and stalled.
// Reset clears the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_convert_unit
	import hslrgb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // hue_deg[8:0], saturation[17:9], lightness[26:18]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

	logic v1_q, v2_q, v3_q, v4_q;
	logic en1, en2, en3, en4;
	scale_en_t sc_en;

	logic signed [LVL_W-1:0] lo_s1, hi_s1;
	logic [K_W-1:0]          k_r_s1, k_g_s1, k_b_s1;
	logic signed [NUM_W-1:0] num_r_s2, num_g_s2, num_b_s2;
	logic [RGB_W-1:0]        red_s4, green_s4, blue_s4;

	assign en4 = !v4_q || m_axis_tready;
	assign en3 = !v3_q || en4;
	assign en2 = !v2_q || en3;
	assign en1 = !v1_q || en2;

	assign sc_en.s3 = en3;
	assign sc_en.s4 = en4;

	assign s_axis_tready = en1;
	assign m_axis_tvalid = v4_q;
	assign m_axis_tdata  = {8'b0, blue_s4, green_s4, red_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (en1)
				v1_q <= s_axis_tvalid;
			if (en2)
				v2_q <= v1_q;
			if (en3)
				v3_q <= v2_q;
			if (en4)
				v4_q <= v3_q;
		end
	end

	hslrgb_levels u_levels (
		.clk        (clk),
		.en         (en1),
		.hue_deg    (s_axis_tdata[8:0]),
		.saturation (s_axis_tdata[17:9]),
		.lightness  (s_axis_tdata[26:18]),
		.lo_s1      (lo_s1),
		.hi_s1      (hi_s1),
		.k_r_s1     (k_r_s1),
		.k_g_s1     (k_g_s1),
		.k_b_s1     (k_b_s1)
	);

	hslrgb_ramp u_ramp_r (.clk(clk), .en(en2), .lo(lo_s1), .hi(hi_s1), .k(k_r_s1),
		.num_s2(num_r_s2));
	hslrgb_ramp u_ramp_g (.clk(clk), .en(en2), .lo(lo_s1), .hi(hi_s1), .k(k_g_s1),
		.num_s2(num_g_s2));
	hslrgb_ramp u_ramp_b (.clk(clk), .en(en2), .lo(lo_s1), .hi(hi_s1), .k(k_b_s1),
		.num_s2(num_b_s2));

	hslrgb_scale u_scale_r (.clk(clk), .en(sc_en), .num(num_r_s2), .chan_s4(red_s4));
	hslrgb_scale u_scale_g (.clk(clk), .en(sc_en), .num(num_g_s2), .chan_s4(green_s4));
	hslrgb_scale u_scale_b (.clk(clk), .en(sc_en), .num(num_b_s2), .chan_s4(blue_s4));

endmodule
`default_nettype wire

>>> rtl/hslrgb_levels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hslrgb_levels
// Stage 1: high and low levels, ramp weights for the three channels.
// ----------------------------------------------------------------------------
module hslrgb_levels
	import hslrgb_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [CH_W-1:0]         hue_deg,
	input  wire logic [CH_W-1:0]         saturation,
	input  wire logic [CH_W-1:0]         lightness,
	output logic signed [LVL_W-1:0]      lo_s1,
	output logic signed [LVL_W-1:0]      hi_s1,
	output logic [K_W-1:0]               k_r_s1,
	output logic [K_W-1:0]               k_g_s1,
	output logic [K_W-1:0]               k_b_s1
);

	logic [2*CH_W-1:0]          ls;
	logic [CH_W:0]              lsum;
	logic [LVL_W-1:0]           hi_c;
	logic signed [LVL_W-1:0]    lo_c;
	logic signed [POS_W-1:0]    h_s;

	assign ls   = {{CH_W{1'b0}}, lightness} * {{CH_W{1'b0}}, saturation};
	assign lsum = {1'b0, lightness} + {1'b0, saturation};

	// zero saturation collapses both levels to lightness
	always_comb begin
		if (saturation == '0)
			hi_c = {2'b00, lightness, 8'b0};
		else if (lightness < HALF_L)
			hi_c = {2'b00, lightness, 8'b0} + {1'b0, ls};
		else
			hi_c = {1'b0, lsum, 8'b0} - {1'b0, ls};
	end

	assign lo_c = $signed({1'b0, lightness, 9'b0}) - $signed(hi_c);
	assign h_s  = $signed({2'b00, hue_deg});

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1  <= $signed(hi_c);
			lo_s1  <= lo_c;
			k_r_s1 <= ramp_weight(wrap_pos(h_s + THIRD_DEG_S));
			k_g_s1 <= ramp_weight(wrap_pos(h_s));
			k_b_s1 <= ramp_weight(wrap_pos(h_s - THIRD_DEG_S));
		end
	end

endmodule
`default_nettype wire

>>> rtl/hslrgb_ramp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hslrgb_ramp
// Stage 2: blend of the two levels for one channel, lo*(60-k) + hi*k.
// ----------------------------------------------------------------------------
module hslrgb_ramp
	import hslrgb_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [LVL_W-1:0] lo,
	input  wire logic signed [LVL_W-1:0] hi,
	input  wire logic [K_W-1:0]          k,
	output logic signed [NUM_W-1:0]      num_s2
);

	logic [K_W-1:0]          k_lo;
	logic signed [NUM_W-1:0] prod_lo;
	logic signed [NUM_W-1:0] prod_hi;

	assign k_lo    = K_FULL - k;
	assign prod_lo = $signed({{(NUM_W-LVL_W){lo[LVL_W-1]}}, lo})
		* $signed({{(NUM_W-K_W){1'b0}}, k_lo});
	assign prod_hi = $signed({{(NUM_W-LVL_W){hi[LVL_W-1]}}, hi})
		* $signed({{(NUM_W-K_W){1'b0}}, k});

	always_ff @(posedge clk) begin
		if (en)
			num_s2 <= prod_lo + prod_hi;
	end

endmodule
`default_nettype wire

>>> rtl/hslrgb_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hslrgb_scale
// Stages 3-4: floor(num*255 / (60*2^16)) limited to 0..255 for one channel.
// ----------------------------------------------------------------------------
module hslrgb_scale
	import hslrgb_pkg::*;
(
	input  wire logic                    clk,
	input  wire scale_en_t               en,
	input  wire logic signed [NUM_W-1:0] num,
	output logic [RGB_W-1:0]             chan_s4
);

	logic [NUM_W-2:0]               num_u;
	logic [NUM_W+6:0]               x255;
	logic [NUM_W-12:0]              q_full;
	logic [Q_W-1:0]                 q_c;
	logic [Q_W-1:0]                 q_s3;
	logic [Q_W+14:0]                prod;

	// num*255 then divide by 2^18; the remaining /15 follows in stage 4
	assign num_u  = num[NUM_W-2:0];
	assign x255   = {num_u, 8'b0} - {8'b0, num_u};
	assign q_full = x255[NUM_W+6:RECIP_SHIFT];

	always_comb begin
		if (num <= 0)
			q_c = '0;
		else if (q_full > {{(NUM_W-11-Q_W){1'b0}}, Q_CAP})
			q_c = Q_CAP;
		else
			q_c = q_full[Q_W-1:0];
	end

	assign prod = {15'b0, q_s3} * {{Q_W{1'b0}}, RECIP_15};

	always_ff @(posedge clk) begin
		if (en.s3)
			q_s3 <= q_c;
		if (en.s4)
			chan_s4 <= prod[RECIP_SHIFT+RGB_W-1:RECIP_SHIFT];
	end

endmodule
`default_nettype wire
